// ===== hw/rtl/swish_activation_unit_top_macros.svh =====
// ----------------------------------------------------------------------------
// Swish activation unit assertion macros
// Shared property wrappers for the top level checks.
// ----------------------------------------------------------------------------
`ifndef SWISH_ACTIVATION_UNIT_TOP_MACROS_SVH
`define SWISH_ACTIVATION_UNIT_TOP_MACROS_SVH

// cond in this cycle implies nxt in the following cycle
`define SWISH_ASSERT_NEXT(lbl, cond, nxt, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

// cond implies prop in the same cycle
`define SWISH_ASSERT_NOW(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// ===== hw/rtl/swish_pkg.sv =====
// ----------------------------------------------------------------------------
// Swish activation unit package
// Beat types, stage indexes, arithmetic widths and the sigmoid table builder.
// ----------------------------------------------------------------------------
package swish_pkg;

   localparam int FracBits  = 12;
   localparam int ValueW    = 16;
   localparam int SigDepth  = 256;
   localparam int SigIdxW   = 8;
   localparam int RemW      = ValueW - SigIdxW;
   localparam int SigW      = FracBits + 1;
   localparam int OperandW  = ValueW + 1;
   localparam int MulW      = OperandW + SigW + 1;
   localparam int InnerW    = 32;
   localparam int ProdW     = 48;
   localparam int RoundSh   = 2 * FracBits;
   localparam int NumStages = 6;

   localparam int StageLookup = 0;
   localparam int StageInterp = 1;
   localparam int StageMul    = 2;
   localparam int StageInner  = 3;
   localparam int StageProd   = 4;
   localparam int StageOut    = 5;

   localparam logic ModeForward  = 1'b0;
   localparam logic ModeGradient = 1'b1;

   localparam logic signed [OperandW-1:0] OneFx    = OperandW'(1 << FracBits);
   localparam logic signed [ProdW-1:0]    RoundBias = ProdW'(1) <<< (RoundSh - 1);

   localparam longint unsigned Q60One = 64'h1000_0000_0000_0000;
   localparam longint unsigned Low30  = 64'h0000_0000_3FFF_FFFF;
   localparam longint unsigned TStep  = 64'h0002_0000_0000_0000;

   typedef struct packed {
      logic                     mode;
      logic signed [ValueW-1:0] x_value;
      logic signed [ValueW-1:0] y_value;
      logic signed [ValueW-1:0] dy_value;
      logic                     last_element;
   } swish_req_type;

   typedef struct packed {
      logic signed [ValueW-1:0] result_value;
      logic                     saturated;
      logic                     last_result;
   } swish_rsp_type;

   typedef struct packed {
      logic lookup;
      logic interp;
   } swish_adv_type;

   function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
      longint unsigned ah, al, bh, bl, mid;
      ah  = a >> 30;
      al  = a & Low30;
      bh  = b >> 30;
      bl  = b & Low30;
      mid = ah * bl + al * bh + ((al * bl) >> 30);
      return ah * bh + (mid >> 30);
   endfunction

   // exp(-|v|) in Q60 with v = -8 + k/16: series on |v|/64, then six squarings
   function automatic longint unsigned sig_exp(int unsigned k);
      longint unsigned m, t, e, term, sum;
      logic            upper;
      upper = (2 * k >= SigDepth);
      m     = upper ? 64'(2 * k - SigDepth) : 64'(SigDepth - 2 * k);
      t     = m * TStep;
      sum   = Q60One;
      term  = Q60One;
      for (int n = 1; n <= 16; n++) begin
         term = mul_q60(term, t) / 64'(n);
         if ((n & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      e = sum;
      for (int i = 0; i < 6; i++) begin
         e = mul_q60(e, e);
      end
      return e;
   endfunction

endpackage

// ===== hw/rtl/swish_activation_unit_top.sv =====
// ----------------------------------------------------------------------------
// Swish activation unit
// Elementwise swish and swish gradient on Q4.12 values, six-stage pipeline.
//
//   channel  valid      stall      payload
//   input    req_valid  req_stall  req_data (swish_req_type)
//   output   rsp_valid  rsp_stall  rsp_data (swish_rsp_type)
//
// One beat per cycle in and out while the output is not stalled.
// Stages: table read, interpolation, sigmoid multiply, inner sum,
// gradient multiply, round and saturate.
// Reset clears the stage valid bits only.
// A stall on the output holds each full stage with no empty stage after it; empty stages still fill.
// ----------------------------------------------------------------------------
`include "swish_activation_unit_top_macros.svh"

module swish_activation_unit_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  swish_pkg::swish_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output swish_pkg::swish_rsp_type rsp_data
);
   import swish_pkg::*;

   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;
   logic [NumStages-1:0] adv;
   swish_adv_type        sig_adv;
   logic [SigW-1:0]      sigmoid;

   swish_req_type              s0_ff;
   swish_req_type              s1_ff;
   logic signed [OperandW-1:0] omy_in;
   logic signed [OperandW-1:0] omy_ff;

   logic signed [OperandW-1:0] mul_a;
   logic signed [MulW-1:0]     mul_in;
   logic signed [MulW-1:0]     mul_ff;
   logic                       mode2_ff;
   logic signed [ValueW-1:0]   y2_ff;
   logic signed [ValueW-1:0]   dy2_ff;
   logic                       last2_ff;

   logic signed [InnerW-1:0]   inner_in;
   logic signed [InnerW-1:0]   inner_ff;
   logic                       mode3_ff;
   logic signed [ValueW-1:0]   dy3_ff;
   logic                       last3_ff;

   logic signed [ProdW-1:0]    prod_in;
   logic signed [ProdW-1:0]    prod_ff;
   logic                       last4_ff;

   logic signed [ProdW-1:0]    rnd;
   logic [ProdW-RoundSh-1:0]   r_top;
   logic                       sat;
   swish_rsp_type              rsp_in;
   swish_rsp_type              rsp_ff;

   // advance chain: a stage moves when empty or when its successor moves
   always_comb begin
      adv[NumStages-1] = !vld_ff[NumStages-1] || !rsp_stall;
      for (int i = NumStages - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign vld_in    = {vld_ff[NumStages-2:0], req_valid};
   assign req_stall = !adv[StageLookup];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (vld_ff & ~adv) | (vld_in & adv);
      end
   end

   assign sig_adv.lookup = adv[StageLookup];
   assign sig_adv.interp = adv[StageInterp];

   swish_sigmoid u_sigmoid (
      .clock   (clock),
      .adv     (sig_adv),
      .x_value (req_data.x_value),
      .sigmoid (sigmoid)
   );

   always_ff @(posedge clock) begin
      if (adv[StageLookup]) begin
         s0_ff <= req_data;
      end
   end

   assign omy_in = OneFx - OperandW'(s0_ff.y_value);

   always_ff @(posedge clock) begin
      if (adv[StageInterp]) begin
         s1_ff  <= s0_ff;
         omy_ff <= omy_in;
      end
   end

   // forward: x * s, gradient: s * (1 - y)
   assign mul_a  = (s1_ff.mode == ModeGradient) ? omy_ff : OperandW'(s1_ff.x_value);
   assign mul_in = MulW'(mul_a) * MulW'($signed({1'b0, sigmoid}));

   always_ff @(posedge clock) begin
      if (adv[StageMul]) begin
         mul_ff   <= mul_in;
         mode2_ff <= s1_ff.mode;
         y2_ff    <= s1_ff.y_value;
         dy2_ff   <= s1_ff.dy_value;
         last2_ff <= s1_ff.last_element;
      end
   end

   always_comb begin
      if (mode2_ff == ModeGradient) begin
         inner_in = (InnerW'(y2_ff) <<< FracBits) + InnerW'(mul_ff);
      end else begin
         inner_in = InnerW'(mul_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[StageInner]) begin
         inner_ff <= inner_in;
         mode3_ff <= mode2_ff;
         dy3_ff   <= dy2_ff;
         last3_ff <= last2_ff;
      end
   end

   // align forward to the gradient scale so one rounding step serves both
   always_comb begin
      if (mode3_ff == ModeGradient) begin
         prod_in = ProdW'(dy3_ff) * ProdW'(inner_ff);
      end else begin
         prod_in = ProdW'(inner_ff) <<< FracBits;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[StageProd]) begin
         prod_ff  <= prod_in;
         last4_ff <= last3_ff;
      end
   end

   always_comb begin
      rnd   = prod_ff + RoundBias;
      r_top = rnd[ProdW-1:RoundSh];
      sat   = !((&r_top[ProdW-RoundSh-1:ValueW-1]) || !(|r_top[ProdW-RoundSh-1:ValueW-1]));
      rsp_in.saturated   = sat;
      rsp_in.last_result = last4_ff;
      if (!sat) begin
         rsp_in.result_value = r_top[ValueW-1:0];
      end else if (r_top[ProdW-RoundSh-1]) begin
         rsp_in.result_value = {1'b1, {(ValueW-1){1'b0}}};
      end else begin
         rsp_in.result_value = {1'b0, {(ValueW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[StageOut]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[StageOut];
   assign rsp_data  = rsp_ff;

   `SWISH_ASSERT_NEXT(a_accept_enters, req_valid && !req_stall, vld_ff[StageLookup], "accepted beat lost at entry")
   `SWISH_ASSERT_NEXT(a_mul_holds, vld_ff[StageMul] && !adv[StageMul], vld_ff[StageMul], "held stage dropped its beat")
   `SWISH_ASSERT_NOW(a_stall_full, req_stall, (&vld_ff) && rsp_stall, "input stalled with room in the pipeline")

endmodule

// ===== hw/rtl/swish_sigmoid.sv =====
// ----------------------------------------------------------------------------
// Swish sigmoid lookup
// Two-stage table lookup with linear interpolation on the low input bits.
// ----------------------------------------------------------------------------
module swish_sigmoid (
   input  logic                                  clock,
   input  swish_pkg::swish_adv_type              adv,
   input  logic signed [swish_pkg::ValueW-1:0]   x_value,
   output logic        [swish_pkg::SigW-1:0]     sigmoid
);
   import swish_pkg::*;

   logic [SigW-1:0]      rom [SigDepth];
   logic [ValueW-1:0]    u;
   logic [SigIdxW-1:0]   idx;
   logic [SigIdxW-1:0]   idx_nx;
   logic [SigW-1:0]      lo;
   logic [SigW-1:0]      hi;
   logic [SigW-1:0]      lo_ff;
   logic [SigW-1:0]      diff_in;
   logic [SigW-1:0]      diff_ff;
   logic [RemW-1:0]      rem_ff;
   logic [SigW+RemW-1:0] step_prod;
   logic [SigW-1:0]      s_in;
   logic [SigW-1:0]      s_ff;

   // round(2^F / (1 + exp(-v))), ties upward
   for (genvar k = 0; k < SigDepth; k++) begin : g_rom
      localparam longint unsigned Ex  = sig_exp(k);
      localparam longint unsigned Num = (2 * k >= SigDepth) ? Q60One : Ex;
      localparam longint unsigned Den = Q60One + Ex;
      localparam longint unsigned Quo =
         (((Num >> 20) << (FracBits + 1)) / (Den >> 20) + 64'd1) >> 1;
      localparam logic [SigW-1:0] Entry = SigW'(Quo);
      assign rom[k] = Entry;
   end

   // offset x by +8.0: flip the sign bit
   assign u      = {~x_value[ValueW-1], x_value[ValueW-2:0]};
   assign idx    = u[ValueW-1:RemW];
   assign idx_nx = idx + SigIdxW'(1);

   always_comb begin
      lo = rom[idx];
      hi = (idx == SigIdxW'(SigDepth - 1)) ? lo : rom[idx_nx];
      diff_in = (hi > lo) ? hi - lo : '0;
   end

   always_ff @(posedge clock) begin
      if (adv.lookup) begin
         lo_ff   <= lo;
         diff_ff <= diff_in;
         rem_ff  <= u[RemW-1:0];
      end
   end

   assign step_prod = (SigW+RemW)'(diff_ff) * (SigW+RemW)'(rem_ff);
   assign s_in      = lo_ff + step_prod[SigW+RemW-1:RemW];

   always_ff @(posedge clock) begin
      if (adv.interp) begin
         s_ff <= s_in;
      end
   end

   assign sigmoid = s_ff;

endmodule
